// ===== rtl/msd_pkg.sv =====
// shared types, constants and code table for the morse symbol decoder
package msd_pkg;

  // buffer sizing
  localparam int MAX_SYMBOLS = 9;
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int CODE_COUNT  = 48;
  localparam int CODE_MAXLEN = 6;
  localparam int LEN_W       = 3;
  localparam int BUF_W       = 8 * CODE_MAXLEN;

  // special bytes
  localparam logic [7:0] CH_BANG     = "!";
  localparam logic [7:0] CH_SPACE    = " ";
  localparam logic [7:0] CH_SLASH    = "/";
  localparam logic [7:0] CH_UNKNOWN  = "?";
  localparam logic [7:0] CH_LOWER_A  = "a";
  localparam logic [7:0] CH_LOWER_Z  = "z";
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // token class decided in the front part
  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_BANG = 2'd2
  } kind_t;

  // classified input item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] sym_byte;
    logic       is_last;
  } tok_t;

  // result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_text;
  } res_t;

  // one code table entry; symbols are right aligned, last symbol in the low byte
  typedef struct packed {
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic [BUF_W-1:0] sym;
  } code_t;

  localparam code_t CODE_TABLE [CODE_COUNT] = '{
    '{"a", 3'd2, BUF_W'("ra")},    '{"b", 3'd4, BUF_W'("arrr")},
    '{"c", 3'd4, BUF_W'("arar")},  '{"d", 3'd3, BUF_W'("arr")},
    '{"e", 3'd1, BUF_W'("r")},     '{"f", 3'd4, BUF_W'("rrar")},
    '{"g", 3'd3, BUF_W'("aar")},   '{"h", 3'd4, BUF_W'("rrrr")},
    '{"i", 3'd2, BUF_W'("rr")},    '{"j", 3'd4, BUF_W'("raaa")},
    '{"k", 3'd3, BUF_W'("ara")},   '{"l", 3'd4, BUF_W'("rarr")},
    '{"m", 3'd2, BUF_W'("aa")},    '{"n", 3'd2, BUF_W'("ar")},
    '{"o", 3'd3, BUF_W'("aaa")},   '{"p", 3'd4, BUF_W'("raar")},
    '{"q", 3'd4, BUF_W'("aara")},  '{"r", 3'd3, BUF_W'("rar")},
    '{"s", 3'd3, BUF_W'("rrr")},   '{"t", 3'd1, BUF_W'("a")},
    '{"u", 3'd3, BUF_W'("rra")},   '{"v", 3'd4, BUF_W'("aaar")},
    '{"w", 3'd3, BUF_W'("raa")},   '{"x", 3'd4, BUF_W'("arra")},
    '{"y", 3'd4, BUF_W'("araa")},  '{"z", 3'd4, BUF_W'("aarr")},
    '{"0", 3'd5, BUF_W'("aaaaa")}, '{"1", 3'd5, BUF_W'("naaaa")},
    '{"2", 3'd5, BUF_W'("nnaaa")}, '{"3", 3'd5, BUF_W'("nnnaa")},
    '{"4", 3'd5, BUF_W'("nnnna")}, '{"5", 3'd5, BUF_W'("nnnnn")},
    '{"6", 3'd5, BUF_W'("annnn")}, '{"7", 3'd5, BUF_W'("aannn")},
    '{"8", 3'd5, BUF_W'("aaann")}, '{"9", 3'd5, BUF_W'("aaaan")},
    '{" ", 3'd2, BUF_W'("ts")},
    '{".", 3'd5, BUF_W'("rrara")}, '{",", 3'd5, BUF_W'("rraar")},
    '{":", 3'd5, BUF_W'("aaara")}, '{"?", 3'd5, BUF_W'("rarra")},
    '{"-", 3'd5, BUF_W'("arraa")}, '{"(", 3'd5, BUF_W'("arara")},
    '{")", 3'd6, BUF_W'("raarra")},
    '{"\"", 3'd5, BUF_W'("aarrr")}, '{"&", 3'd5, BUF_W'("rrrra")},
    '{"!", 3'd5, BUF_W'("rrraa")},  '{";", 3'd5, BUF_W'("raraa")}
  };

  // parallel exact match of the buffered letter against every code
  function automatic logic [7:0] lookup(input logic [CNT_W-1:0] cnt,
                                        input logic [BUF_W-1:0] buf_v);
    logic [7:0]       ch;
    logic [BUF_W-1:0] mask;
    ch = CH_UNKNOWN;
    for (int i = CODE_COUNT - 1; i >= 0; i--) begin
      mask = (BUF_W'(1) << (8 * CODE_TABLE[i].len)) - BUF_W'(1);
      if (cnt == CNT_W'(CODE_TABLE[i].len) && (buf_v & mask) == CODE_TABLE[i].sym) begin
        ch = CODE_TABLE[i].ch;
      end
    end
    return ch;
  endfunction

endpackage

// ===== rtl/msd_front.sv =====
// front part: classifies input bytes and queues the tokens
module msd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    sym_byte,
  input  logic          is_last,
  input  logic          tok_pop,
  output logic          tok_valid,
  output msd_pkg::tok_t tok
);

  msd_pkg::tok_t tok_in;
  msd_pkg::tok_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  // classify the byte
  always_comb begin
    tok_in.sym_byte = sym_byte;
    tok_in.is_last  = is_last;
    if (sym_byte == msd_pkg::CH_SPACE || sym_byte == msd_pkg::CH_SLASH) begin
      tok_in.kind = msd_pkg::KIND_SEP;
    end else if (sym_byte == msd_pkg::CH_BANG) begin
      tok_in.kind = msd_pkg::KIND_BANG;
    end else begin
      tok_in.kind = msd_pkg::KIND_SYM;
    end
  end

  // two-entry token queue
  assign full      = (cnt_r == 2'd2);
  assign tok_valid = (cnt_r != 2'd0);
  assign tok       = mem_r[rp_r];
  assign push_ok   = push && !full;
  assign pop_ok    = tok_pop && tok_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/msd_res_fifo.sv =====
// result queue between the back part and the output ports
module msd_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  msd_pkg::res_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output msd_pkg::res_t pop_data
);

  msd_pkg::res_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/msd_back.sv =====
// back part: letter buffer, code match and capital flag
module msd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid,
  input  msd_pkg::tok_t tok,
  output logic          tok_pop,
  input  logic          res_full,
  output logic          res_push,
  output msd_pkg::res_t res
);

  logic [msd_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic [msd_pkg::BUF_W-1:0] buf_r, buf_after;
  logic                      cap_r, cap_nxt, cap_after;
  logic                      fire, bang_now, store, do_finish, is_letter;
  logic [7:0]                code_ch, dec_ch;

  // one token per cycle while the result queue has room
  assign fire    = tok_valid && !res_full;
  assign tok_pop = fire;

  // buffer update for this token
  always_comb begin
    bang_now  = (tok.kind == msd_pkg::KIND_BANG) && (cnt_r == '0);
    store     = !bang_now && (tok.kind != msd_pkg::KIND_SEP) &&
                (cnt_r < msd_pkg::CNT_W'(msd_pkg::MAX_SYMBOLS));
    cnt_after = store ? cnt_r + msd_pkg::CNT_W'(1) : cnt_r;
    buf_after = store ? {buf_r[msd_pkg::BUF_W-9:0], tok.sym_byte} : buf_r;
    cap_after = cap_r || bang_now;
    do_finish = ((tok.kind == msd_pkg::KIND_SEP) || tok.is_last) && (cnt_after != '0);
  end

  // decode and apply the capital flag
  always_comb begin
    code_ch   = msd_pkg::lookup(cnt_after, buf_after);
    is_letter = (code_ch >= msd_pkg::CH_LOWER_A) && (code_ch <= msd_pkg::CH_LOWER_Z);
    dec_ch    = (cap_after && is_letter) ? code_ch - msd_pkg::CASE_OFFSET : code_ch;
  end

  // next state
  always_comb begin
    cnt_nxt = cnt_after;
    cap_nxt = cap_after;
    if (tok.is_last) begin
      cnt_nxt = '0;
      cap_nxt = 1'b0;
    end else if (do_finish) begin
      cnt_nxt = '0;
      cap_nxt = cap_after && !is_letter;
    end
  end

  // result
  assign res_push        = fire && (do_finish || tok.is_last);
  assign res.out_char    = do_finish ? dec_ch : 8'd0;
  assign res.has_char    = do_finish;
  assign res.end_of_text = tok.is_last;

  always_ff @(posedge clk) begin
    if (fire) begin
      buf_r <= buf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= 1'b0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      cap_r <= cap_nxt;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= msd_pkg::CNT_W'(msd_pkg::MAX_SYMBOLS))
    else $error("symbol count above buffer size");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && tok.is_last |=> cnt_r == '0 && !cap_r)
    else $error("state not cleared after last item");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_empty_only_eot: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && !res.has_char |-> res.end_of_text && res.out_char == 8'd0)
    else $error("empty result outside end of text");

endmodule

// ===== rtl/morse_symbol_decoder.sv =====
// top level of the morse symbol decoder
// Takes one text byte per cycle while in_full is low and gives at most one
// decoded character per byte. A result passes from the token queue through
// the back stage into the result queue, whose head drives the out_ ports. The
// back stage decodes a whole letter with a combinational parallel compare
// against the 48-entry code table, so it takes one byte per cycle while the
// result queue has room. Two-entry queues sit on either side of the back
// stage, so a stalled reader holds the writer off only once both queues are
// full. Bytes 'r'/'n' are dots, 'a' a dash, space or slash ends a letter, and
// the byte flagged in_is_last always yields a result with out_end_of_text set
// and clears the decoder state.
module morse_symbol_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_sym_byte,
  input  logic       in_is_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_has_char,
  output logic       out_end_of_text
);

  msd_pkg::tok_t tok;
  msd_pkg::res_t res_in, res_out;
  logic          tok_valid, tok_pop, res_push, res_full;

  // classify and queue input bytes
  msd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .sym_byte (in_sym_byte),
    .is_last  (in_is_last),
    .tok_pop  (tok_pop),
    .tok_valid(tok_valid),
    .tok      (tok)
  );

  // decode letters
  msd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_valid(tok_valid),
    .tok      (tok),
    .tok_pop  (tok_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // result queue
  msd_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .empty    (out_empty),
    .pop_data (res_out)
  );

  assign out_char        = res_out.out_char;
  assign out_has_char    = res_out.has_char;
  assign out_end_of_text = res_out.end_of_text;

endmodule
